>>> hdl/isfc_pkg.sv
// Shared types, constants and the byte-wide CRC step for the SPI frame codec.
package isfc_pkg;

    // Frame geometry
    localparam int FRAME_W   = 48;
    localparam int CRC_BYTES = FRAME_W / 8;

    // CRC-8 definition, MSB first
    localparam logic [7:0] CRC_POLY = 8'h2F;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Opcodes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    // One beat in flight through the CRC pipeline
    typedef struct packed {
        logic               valid;
        logic [1:0]         opcode;
        logic [FRAME_W-1:0] frame;
        logic [7:0]         crc;
    } stage_t;

    // Eight MSB-first CRC steps over one data byte
    function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in;
        for (int i = 7; i >= 0; i--) begin
            if (c[7]) begin
                c = {c[6:0], data[i]} ^ CRC_POLY;
            end else begin
                c = {c[6:0], data[i]};
            end
        end
        return c;
    endfunction

endpackage

>>> hdl/isfc_prep.sv
// Input stage: assembles the request frame or takes the received frame.
module isfc_prep
    import isfc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               in_valid,
    input  logic [1:0]         opcode,
    input  logic [9:0]         reg_addr,
    input  logic [19:0]        write_data,
    input  logic [FRAME_W-1:0] frame_in,
    output stage_t             stage_out
);

    logic               valid_reg;
    logic [1:0]         opcode_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [FRAME_W-1:0] frame_next;
    logic               is_write;

    // Request layout: addr, write flag, fixed one at bit 35, data, CRC slot
    assign is_write = (opcode == OP_WRITE);

    always_comb begin
        if (opcode == OP_CHECK) begin
            frame_next = frame_in;
        end else begin
            frame_next = {reg_addr, is_write, 1'b0, 1'b1, 7'd0,
                          is_write ? write_data : 20'd0, 8'd0};
        end
    end

    // Valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            opcode_reg <= opcode;
            frame_reg  <= frame_next;
        end
    end

    assign stage_out = '{valid: valid_reg, opcode: opcode_reg, frame: frame_reg, crc: CRC_INIT};

endmodule

>>> hdl/isfc_crc_stage.sv
// One CRC pipeline stage: folds one frame byte into the running CRC.
module isfc_crc_stage
    import isfc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  stage_t     stage_in,
    input  logic [7:0] data_byte,
    output stage_t     stage_out
);

    logic               valid_reg;
    logic [1:0]         opcode_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [7:0]         crc_reg;
    logic [7:0]         crc_next;

    assign crc_next = crc_byte(stage_in.crc, data_byte);

    // Valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= stage_in.valid;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            opcode_reg <= stage_in.opcode;
            frame_reg  <= stage_in.frame;
            crc_reg    <= crc_next;
        end
    end

    assign stage_out = '{valid: valid_reg, opcode: opcode_reg, frame: frame_reg, crc: crc_reg};

endmodule

>>> hdl/isfc_out.sv
// Output stage: CRC compare, field extraction and the result register.
module isfc_out
    import isfc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  stage_t             stage_in,
    output logic               out_valid,
    output logic [FRAME_W-1:0] frame_out,
    output logic               crc_ok,
    output logic [7:0]         crc_value,
    output logic [9:0]         source_addr,
    output logic signed [19:0] value20,
    output logic signed [15:0] temp_code,
    output logic [15:0]        reg_data16
);

    logic               valid_reg;
    logic [FRAME_W-1:0] frame_reg,  frame_next;
    logic               ok_reg,     ok_next;
    logic [7:0]         crc_reg,    crc_next;
    logic [9:0]         addr_reg,   addr_next;
    logic [19:0]        val_reg,    val_next;
    logic [15:0]        rdata_reg,  rdata_next;
    logic               match;

    assign match = (stage_in.crc == stage_in.frame[7:0]);

    // Result fields by opcode
    always_comb begin
        frame_next = '0;
        ok_next    = 1'b0;
        crc_next   = 8'd0;
        addr_next  = 10'd0;
        val_next   = 20'd0;
        rdata_next = 16'd0;
        case (stage_in.opcode)
            OP_READ, OP_WRITE: begin
                frame_next = {stage_in.frame[FRAME_W-1:8], stage_in.crc};
                ok_next    = 1'b1;
                crc_next   = stage_in.crc;
            end
            OP_CHECK: begin
                crc_next = stage_in.crc;
                ok_next  = match;
                if (match) begin
                    addr_next  = stage_in.frame[46:37];
                    val_next   = stage_in.frame[27:8];
                    rdata_next = stage_in.frame[23:8];
                end
            end
            default: begin
                ok_next = 1'b0;
            end
        endcase
    end

    // Valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= stage_in.valid;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            frame_reg <= frame_next;
            ok_reg    <= ok_next;
            crc_reg   <= crc_next;
            addr_reg  <= addr_next;
            val_reg   <= val_next;
            rdata_reg <= rdata_next;
        end
    end

    assign out_valid   = valid_reg;
    assign frame_out   = frame_reg;
    assign crc_ok      = ok_reg;
    assign crc_value   = crc_reg;
    assign source_addr = addr_reg;
    assign value20     = val_reg;
    assign temp_code   = val_reg[19:4];
    assign reg_data16  = rdata_reg;

endmodule

>>> hdl/imu_spi48_frame_codec.sv
// Eight register stages (prep, six CRC byte stages, output) lie between an accepted
// input beat and m_valid, the first loaded at the accepting edge.
// Throughput: one beat per cycle unless stalled; the CRC folds one byte per stage.
// Back pressure: all stages advance together; s_ready = !m_valid || m_ready.
// Reset: aresetn synchronous, active low; clears all valid bits, payload is not reset.
// Top level of the 48-bit SPI frame codec.
module imu_spi48_frame_codec
    import isfc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [9:0]         s_reg_addr,
    input  logic [19:0]        s_write_data,
    input  logic [47:0]        s_frame_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [47:0]        m_frame_out,
    output logic               m_crc_ok,
    output logic [7:0]         m_crc_value,
    output logic [9:0]         m_source_addr,
    output logic signed [19:0] m_value20,
    output logic signed [15:0] m_temp_code,
    output logic [15:0]        m_reg_data16
);

    logic   advance;
    stage_t crc_pipe [0:CRC_BYTES];

    // Whole pipeline moves when the result register can take a beat
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    isfc_prep u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .in_valid   (s_valid),
        .opcode     (s_opcode),
        .reg_addr   (s_reg_addr),
        .write_data (s_write_data),
        .frame_in   (s_frame_in),
        .stage_out  (crc_pipe[0])
    );

    // CRC stages, high byte first; the CRC slot counts as zero
    for (genvar i = 0; i < CRC_BYTES; i++) begin : g_crc
        logic [7:0] data_byte;
        if (i == CRC_BYTES - 1) begin : g_slot
            assign data_byte = 8'd0;
        end else begin : g_data
            assign data_byte = crc_pipe[i].frame[FRAME_W-1-8*i -: 8];
        end

        isfc_crc_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .stage_in  (crc_pipe[i]),
            .data_byte (data_byte),
            .stage_out (crc_pipe[i+1])
        );
    end

    isfc_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .stage_in    (crc_pipe[CRC_BYTES]),
        .out_valid   (m_valid),
        .frame_out   (m_frame_out),
        .crc_ok      (m_crc_ok),
        .crc_value   (m_crc_value),
        .source_addr (m_source_addr),
        .value20     (m_value20),
        .temp_code   (m_temp_code),
        .reg_data16  (m_reg_data16)
    );

`ifndef SYNTHESIS
    // A built frame carries its own CRC in the low byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_frame_out != 48'd0) |-> m_crc_ok && (m_frame_out[7:0] == m_crc_value))
        else $error("built frame CRC slot mismatch");

    // Failed check leaves every decoded field zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_crc_ok |-> (m_source_addr == 10'd0) && (m_value20 == 20'sd0)
                                 && (m_reg_data16 == 16'd0) && (m_frame_out == 48'd0))
        else $error("decoded fields not cleared on CRC failure");

    // Temperature is the top sixteen bits of the value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_temp_code == m_value20[19:4]))
        else $error("temperature field inconsistent with value");

    // An accepted beat reaches the result register when nothing stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 advance ##1 advance ##1 advance ##1 advance
            ##1 advance ##1 advance ##1 advance |=> m_valid)
        else $error("beat lost in pipeline");
`endif

endmodule
